// ----- src/assert_macros.svh -----
// assertion macros shared by the utf-8 decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define U8_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define U8_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- src/u8dbc_pkg.sv -----
// shared types and constants for the utf-8 decoder with break classification
package u8dbc_pkg;

  localparam int CpW    = 21;
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCntW  = QAw + 1;

  // one queue entry: the one or two results caused by one byte
  typedef struct packed {
    logic           two;
    logic [CpW-1:0] r0_cp;
    logic           r0_bad;
    logic [CpW-1:0] r1_cp;
    logic           r1_bad;
  } entry_t;

endpackage

// ----- src/utf8_decode_break_classify.sv -----
// top level of the utf-8 decoder with line-break classification
//
// input channel: one raw utf-8 byte per item on in_byte, in_valid/in_ready
// output channel: one character per item: code_point, is_break, malformed,
//   last_of_run, out_valid/out_ready
// a byte gives zero, one or two results; last_of_run marks the final one
// a byte's results pass through the result queue and then the output
//   register before they are shown
// one byte per cycle while the queue is not full; the two results of one
//   byte play out in turn, and a four-entry queue absorbs the difference
// in_ready is low only while the result queue is full, so a stalled
//   receiver holds back the sender after four queued entries
// the output register keeps its item until out_ready takes it
// reset (rst, synchronous) clears the pending sequence, the queue and the
//   output valid flag; no partial character survives it
module utf8_decode_break_classify
  import u8dbc_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [CpW-1:0] code_point,
  output logic           is_break,
  output logic           malformed,
  output logic           last_of_run
);

  // queue handshake between front and back
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;
  entry_t q_wr;
  entry_t q_head;

  // front: sequence tracking, one byte per cycle while the queue is not full
  u8dbc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_wr)
  );

  // entries of one or two results
  u8dbc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  // back: result play-out and break classification
  u8dbc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_point  (code_point),
    .is_break    (is_break),
    .malformed   (malformed),
    .last_of_run (last_of_run)
  );

endmodule

// ----- src/u8dbc_front.sv -----
// front part: takes bytes, tracks the pending sequence, builds queue entries
module u8dbc_front
  import u8dbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       q_full,
  output logic       q_push,
  output entry_t     q_entry
);

  typedef struct packed {
    logic           emit;
    logic [CpW-1:0] cp;
    logic           bad;
    logic [1:0]     pend;
    logic [CpW-1:0] part;
  } lead_t;

  // decode a byte as the start of a new sequence
  function automatic lead_t lead_decode(input logic [7:0] b);
    lead_t r;
    r = '0;
    if (b[7] == 1'b0) begin
      r.emit = 1'b1;
      r.cp   = {13'd0, b};
    end else if (b[7:5] == 3'b110) begin
      r.pend = 2'd1;
      r.part = {10'd0, b[4:0], 6'd0};
    end else if (b[7:4] == 4'b1110) begin
      r.pend = 2'd2;
      r.part = {5'd0, b[3:0], 12'd0};
    end else if (b[7:3] == 5'b11110) begin
      r.pend = 2'd3;
      r.part = {b[2:0], 18'd0};
    end else begin
      r.emit = 1'b1;
      r.bad  = 1'b1;
    end
    return r;
  endfunction

  logic [1:0]     pending;
  logic [1:0]     pending_next;
  logic [CpW-1:0] partial;
  logic [CpW-1:0] partial_next;
  logic [CpW-1:0] addend;
  logic [CpW-1:0] merged;
  lead_t          lead;
  logic           push_req;
  logic           accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && push_req;

  always_comb begin
    lead         = lead_decode(in_byte);
    pending_next = pending;
    partial_next = partial;
    q_entry      = '0;
    push_req     = 1'b0;
    case (pending)
      2'd3:    addend = {3'd0, in_byte[5:0], 12'd0};
      2'd2:    addend = {9'd0, in_byte[5:0], 6'd0};
      2'd1:    addend = {15'd0, in_byte[5:0]};
      default: addend = '0;
    endcase
    merged = partial | addend;
    if (pending == 2'd0) begin
      pending_next   = lead.pend;
      partial_next   = lead.part;
      q_entry.r0_cp  = lead.cp;
      q_entry.r0_bad = lead.bad;
      push_req       = lead.emit;
    end else if (in_byte[7:6] == 2'b10) begin
      pending_next = pending - 2'd1;
      if (pending == 2'd1) begin
        q_entry.r0_cp = merged;
        push_req      = 1'b1;
        partial_next  = '0;
      end else begin
        partial_next = merged;
      end
    end else begin
      // sequence cut short: report it, then restart on this byte
      q_entry.r0_bad = 1'b1;
      q_entry.two    = lead.emit;
      q_entry.r1_cp  = lead.cp;
      q_entry.r1_bad = lead.bad;
      pending_next   = lead.pend;
      partial_next   = lead.part;
      push_req       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      partial <= '0;
    end else if (accept) begin
      pending <= pending_next;
      partial <= partial_next;
    end
  end

endmodule

// ----- src/u8dbc_fifo.sv -----
// short queue of result entries between front and back
`include "assert_macros.svh"

module u8dbc_fifo
  import u8dbc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_entry,
  input  logic   pop,
  output logic   full,
  output logic   empty,
  output entry_t head
);

  entry_t           mem [QDepth];
  logic [QAw-1:0]   wr_ptr;
  logic [QAw-1:0]   rd_ptr;
  logic [QCntW-1:0] count;

  assign full  = (count == QCntW'(QDepth));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `U8_ASSERT_NEVER(a_no_overflow, push && full && !pop, "push into a full queue")
  `U8_ASSERT_NEVER(a_no_underflow, pop && empty, "pop from an empty queue")
  `U8_ASSERT(a_count_range, count <= QCntW'(QDepth), "queue count out of range")

endmodule

// ----- src/u8dbc_back.sv -----
// back part: plays out queue entries as results and flags break characters
`include "assert_macros.svh"

module u8dbc_back
  import u8dbc_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  entry_t         q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [CpW-1:0] code_point,
  output logic           is_break,
  output logic           malformed,
  output logic           last_of_run
);

  function automatic logic break_class(input logic [CpW-1:0] cp);
    logic hit;
    hit = cp inside {[21'h004E00:21'h009FA5], 21'h20, 21'h2C, 21'h2E, 21'h3B,
                     21'h3A, 21'h2D, 21'h5F};
    return hit;
  endfunction

  logic           second;
  logic           load;
  logic [CpW-1:0] sel_cp;
  logic           sel_bad;
  logic           sel_last;

  assign load = !q_empty && (!out_valid || out_ready);

  always_comb begin
    sel_cp   = second ? q_head.r1_cp : q_head.r0_cp;
    sel_bad  = second ? q_head.r1_bad : q_head.r0_bad;
    sel_last = second || !q_head.two;
  end

  assign q_pop = load && sel_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      second    <= !sel_last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_point  <= sel_cp;
      malformed   <= sel_bad;
      is_break    <= !sel_bad && break_class(sel_cp);
      last_of_run <= sel_last;
    end
  end

  `U8_ASSERT(a_second_has_entry, second |-> (!q_empty && q_head.two),
             "second result pending without a two-result entry")

endmodule

// ----- tb/sv/utf8_char_checker.sv -----
// checker for the utf-8 decoder: predicts the characters of each byte and compares them
`timescale 1ns / 1ps

module utf8_char_checker
  import u8dbc_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           out_valid,
  input  logic           out_ready,
  input  logic [CpW-1:0] code_point,
  input  logic           is_break,
  input  logic           malformed,
  input  logic           last_of_run,
  input  logic           drain_done,
  output int             fail_count,
  output int             chars_waiting
);

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;
  localparam logic [CpW-1:0] CJK_FIRST = 21'h4E00;
  localparam logic [CpW-1:0] CJK_LAST  = 21'h9FA5;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           brk;
    logic           bad;
    logic           last;
  } char_t;

  char_t          expected_chars[$];
  char_t          byte_chars[$];
  logic [1:0]     cont_left = '0;
  logic [CpW-1:0] cp_bits = '0;
  int             errors = 0;
  bit             leftovers_checked = 1'b0;

  assign fail_count    = errors;
  assign chars_waiting = expected_chars.size();

  function automatic logic breaks_line(input logic [CpW-1:0] cp);
    if (cp >= CJK_FIRST && cp <= CJK_LAST) return 1'b1;
    case (cp)
      21'h20, 21'h2C, 21'h2E, 21'h3B, 21'h3A, 21'h2D, 21'h5F: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR %0t ns: %s: got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic put_char(input logic [CpW-1:0] cp, input logic bad);
    char_t c;
    c.cp   = cp;
    c.brk  = !bad && breaks_line(cp);
    c.bad  = bad;
    c.last = 1'b0;
    byte_chars.push_back(c);
  endtask

  // byte seen with no sequence open
  task automatic start_char(input logic [7:0] b);
    if (!b[7]) begin
      put_char(CpW'(b[6:0]), 1'b0);
    end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
      cp_bits   = CpW'(b[4:0]) << 6;
      cont_left = 2'd1;
    end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
      cp_bits   = CpW'(b[3:0]) << 12;
      cont_left = 2'd2;
    end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
      cp_bits   = CpW'(b[2:0]) << 18;
      cont_left = 2'd3;
    end else begin
      put_char('0, 1'b1);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [CpW-1:0] six;
    char_t c;
    byte_chars.delete();
    if (cont_left == 2'd0) begin
      start_char(b);
    end else if ((b & CONT_MASK) == CONT_TAG) begin
      six       = CpW'(b[5:0]);
      cp_bits   = cp_bits | (six << (6 * (int'(cont_left) - 1)));
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        put_char(cp_bits, 1'b0);
        cp_bits = '0;
      end
    end else begin
      // sequence cut short: flag it, then treat the byte as a fresh lead
      put_char('0, 1'b1);
      cont_left = 2'd0;
      cp_bits   = '0;
      start_char(b);
    end
    foreach (byte_chars[i]) begin
      c      = byte_chars[i];
      c.last = (i == byte_chars.size() - 1);
      expected_chars.push_back(c);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      // results leave only after their byte has passed the queue and the output register, so compare before predicting
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("result with nothing expected", code_point, 0);
        end else begin
          char_t want;
          want = expected_chars.pop_front();
          if (code_point !== want.cp) report_mismatch("code_point", code_point, want.cp);
          if (is_break !== want.brk) report_mismatch("is_break", is_break, want.brk);
          if (malformed !== want.bad) report_mismatch("malformed", malformed, want.bad);
          if (last_of_run !== want.last)
            report_mismatch("last_of_run", last_of_run, want.last);
        end
      end
      if (in_valid && in_ready) decode_byte(in_byte);
      if (drain_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_chars.size() != 0)
          report_mismatch("results never delivered", expected_chars.size(), 0);
      end
    end
  end

endmodule

// ----- tb/sv/tb_utf8_decode_break_classify.sv -----
// top of the utf-8 decoder testbench: byte stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module tb_utf8_decode_break_classify;
  import u8dbc_pkg::*;

  localparam int NUM_BYTES   = 1600;
  localparam int QUIET_FROM  = 1450;  // no idling on either side past this point
  localparam int HOLD_AT     = 200;   // bytes sent before the long receiver stall
  localparam int HOLD_CYCLES = 80;

  logic           clk;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [7:0]     in_byte = 8'h00;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [CpW-1:0] code_point;
  logic           is_break;
  logic           malformed;
  logic           last_of_run;
  logic           drain_done = 1'b0;
  int             fail_count;
  int             chars_waiting;

  // stimulus progress, shared with the receiver process
  int             bytes_sent = 0;
  bit             quiet = 1'b0;
  int             gap_odds = 8;

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  utf8_decode_break_classify uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .is_break   (is_break),
    .malformed  (malformed),
    .last_of_run(last_of_run)
  );

  utf8_char_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code_point   (code_point),
    .is_break     (is_break),
    .malformed    (malformed),
    .last_of_run  (last_of_run),
    .drain_done   (drain_done),
    .fail_count   (fail_count),
    .chars_waiting(chars_waiting)
  );

  // offer one byte and hold it until the block takes it; called right after a rising edge
  task automatic send_byte(input logic [7:0] b);
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    // random sender gap, never during the quiet tail
    if (!quiet && gap_odds > 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // send the first keep bytes of the len-byte encoding of cp
  task automatic send_char(input logic [CpW-1:0] cp, input int len, input int keep);
    logic [7:0] enc[4];
    case (len)
      1: enc[0] = {1'b0, cp[6:0]};
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) send_byte(enc[i]);
  endtask

  // receiver: random ready runs and stall bursts, plus one long stall to fill the queue
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && bytes_sent >= HOLD_AT) begin
        // long stall while the sender keeps offering bytes: in_ready must drop
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        // sometimes a long stretch with no stall at all
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(30, 80)) @(posedge clk);
        else repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // stimulus
  initial begin
    logic [7:0] punct[7];
    int pick;
    int len;
    int waited;
    punct = '{8'h20, 8'h2C, 8'h2E, 8'h3B, 8'h3A, 8'h2D, 8'h5F};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: ascii extremes and break punctuation
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h20);
    send_byte(8'h2C);
    send_byte(8'h3A);
    send_byte(8'h2D);
    send_byte(8'h5F);
    // two-byte character
    send_byte(8'hC3);
    send_byte(8'hA9);
    // cjk range ends: first ideograph and last one flagged as a break
    send_byte(8'hE4);
    send_byte(8'hB8);
    send_byte(8'h80);
    send_byte(8'hE9);
    send_byte(8'hBE);
    send_byte(8'hA5);
    // largest four-byte value, all ones in every field
    send_byte(8'hF7);
    send_byte(8'hBF);
    send_byte(8'hBF);
    send_byte(8'hBF);
    // stray continuation while idle, invalid lead
    send_byte(8'h80);
    send_byte(8'hFF);
    // cut-short three-byte sequence restarted by a lead, which is cut short by an invalid lead
    send_byte(8'hE4);
    send_byte(8'hB8);
    send_byte(8'hC3);
    send_byte(8'hFF);
    // cut-short sequence followed by plain ascii: two results from one byte
    send_byte(8'hC3);
    send_byte(8'h41);

    // random: mostly well-formed characters, some truncated sequences and noise
    while (bytes_sent < NUM_BYTES) begin
      if (bytes_sent >= QUIET_FROM) quiet = 1'b1;
      if (bytes_sent % 100 < 4) begin
        case ($urandom_range(0, 2))
          0: gap_odds = 0;
          1: gap_odds = 3;
          default: gap_odds = 10;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        if ($urandom_range(0, 2) == 0) send_byte(punct[$urandom_range(0, 6)]);
        else send_byte(8'($urandom_range(0, 127)));
      end else if (pick < 45) begin
        send_char(CpW'($urandom_range(0, 21'h7FF)), 2, 2);
      end else if (pick < 70) begin
        // about half lands near or inside the cjk range
        if ($urandom_range(0, 1) == 0)
          send_char(CpW'($urandom_range(21'h4DF0, 21'h9FB0)), 3, 3);
        else
          send_char(CpW'($urandom_range(0, 21'hFFFF)), 3, 3);
      end else if (pick < 82) begin
        send_char(CpW'($urandom_range(0, 21'h1FFFFF)), 4, 4);
      end else if (pick < 92) begin
        len = $urandom_range(2, 4);
        send_char(CpW'($urandom_range(0, 21'h1FFFFF)), len, $urandom_range(1, len - 1));
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    in_valid <= 1'b0;

    // drain, then wait for anything unexpected to show up
    waited = 0;
    while (chars_waiting != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    drain_done <= 1'b1;
    repeat (3) @(posedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
